// ===== rtl/rlfd_pkg.sv =====
// rlfd_pkg: shared constants, phase codes and beat types for the run-length
// frame decoder. No dependencies; imported by rlfd_core and the top level.
`timescale 1ns / 1ps

package rlfd_pkg;

    // Decoded size of every frame, in bytes
    localparam int FRAME_BYTES = 1024;

    // Byte counter width: holds 0..FRAME_BYTES
    localparam int CNT_W = $clog2(FRAME_BYTES + 1);

    // Compare width: wide enough for the byte counter and a 1..128 run count
    localparam int CMP_W = (CNT_W > 9) ? CNT_W : 9;

    // Control byte fields
    localparam logic [7:0] CTRL_COUNT_MASK = 8'h7F;
    localparam logic [7:0] CTRL_REPEAT_BIT = 8'h80;

    // Decode phase codes
    localparam logic [1:0] PHASE_CONTROL = 2'd0;
    localparam logic [1:0] PHASE_LITERAL = 2'd1;
    localparam logic [1:0] PHASE_REPEAT  = 2'd2;

    // Encoded input beat
    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_in;
    } enc_beat_t;

    // Decoded result beat
    typedef struct packed {
        logic       data_valid;
        logic [7:0] out_byte;
        logic [7:0] run_count;
        logic       frame_done;
        logic       bad_encoding;
    } dec_beat_t;

endpackage

// ===== rtl/rlfd_core.sv =====
// rlfd_core: decode state (phase, run length, byte count, discard flag, mode)
// and the single-pass next-state / result logic. Depends on rlfd_pkg.
`timescale 1ns / 1ps

module rlfd_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_wdata,
    input  logic               step,
    input  rlfd_pkg::enc_beat_t beat,
    output logic               res_valid,
    output rlfd_pkg::dec_beat_t res
);
    import rlfd_pkg::*;

    logic             raw_mode_reg;
    logic [1:0]       phase_reg,     phase_next;
    logic [7:0]       run_left_reg,  run_left_next;
    logic [CNT_W-1:0] bytes_reg,     bytes_next;
    logic             discard_reg,   discard_next;

    // Widened operands for the space checks
    logic [CMP_W-1:0] bytes_ext;
    logic [CMP_W-1:0] space_ext;
    logic [CMP_W-1:0] ctrl_n_ext;
    logic [CMP_W-1:0] run_ext;
    logic [CMP_W-1:0] new_bytes;
    logic [7:0]       ctrl_n;
    logic             full;

    assign bytes_ext  = CMP_W'(bytes_reg);
    assign space_ext  = CMP_W'(FRAME_BYTES) - bytes_ext;
    assign ctrl_n     = (beat.in_byte & CTRL_COUNT_MASK) + 8'd1;
    assign ctrl_n_ext = CMP_W'(ctrl_n);
    assign run_ext    = CMP_W'(run_left_reg);
    assign full       = bytes_ext >= CMP_W'(FRAME_BYTES);

    // Decode one beat: next state and at most one result
    always_comb
    begin
        logic       err;
        logic       emit;
        logic [7:0] e_byte;
        logic [7:0] e_cnt;

        err           = 1'b0;
        emit          = 1'b0;
        e_byte        = beat.in_byte;
        e_cnt         = 8'd1;
        new_bytes     = bytes_ext;
        phase_next    = phase_reg;
        run_left_next = run_left_reg;
        bytes_next    = bytes_reg;
        discard_next  = discard_reg;
        res_valid     = 1'b0;
        res           = '0;

        if (discard_reg)
        begin
            // Drop the rest of an errored frame
            if (beat.last_in)
            begin
                discard_next = 1'b0;
            end
        end
        else if (raw_mode_reg)
        begin
            if (full)
            begin
                err = 1'b1;
            end
            else
            begin
                new_bytes = bytes_ext + CMP_W'(1);
                emit      = 1'b1;
            end
        end
        else
        begin
            case (phase_reg)
                PHASE_LITERAL:
                begin
                    if (run_left_reg == 8'd0 || full)
                    begin
                        err = 1'b1;
                    end
                    else
                    begin
                        run_left_next = run_left_reg - 8'd1;
                        new_bytes     = bytes_ext + CMP_W'(1);
                        if (run_left_next == 8'd0)
                        begin
                            phase_next = PHASE_CONTROL;
                            emit       = 1'b1;
                        end
                        else if (beat.last_in)
                        begin
                            err = 1'b1;
                        end
                        else
                        begin
                            emit = 1'b1;
                        end
                    end
                end
                PHASE_REPEAT:
                begin
                    if (run_left_reg == 8'd0 || run_ext > space_ext)
                    begin
                        err = 1'b1;
                    end
                    else
                    begin
                        new_bytes     = bytes_ext + run_ext;
                        run_left_next = 8'd0;
                        phase_next    = PHASE_CONTROL;
                        e_cnt         = run_left_reg;
                        emit          = 1'b1;
                    end
                end
                default:
                begin
                    // Control byte
                    if (full || ctrl_n_ext > space_ext || beat.last_in)
                    begin
                        err = 1'b1;
                    end
                    else
                    begin
                        run_left_next = ctrl_n;
                        phase_next    = ((beat.in_byte & CTRL_REPEAT_BIT) != 8'd0)
                                        ? PHASE_REPEAT : PHASE_LITERAL;
                    end
                end
            endcase
        end

        bytes_next = CNT_W'(new_bytes);

        // Last byte of a frame must land exactly on the frame size
        if (emit && beat.last_in && new_bytes != CMP_W'(FRAME_BYTES))
        begin
            emit = 1'b0;
            err  = 1'b1;
        end

        if (err)
        begin
            phase_next       = PHASE_CONTROL;
            run_left_next    = 8'd0;
            bytes_next       = '0;
            discard_next     = !beat.last_in;
            res_valid        = 1'b1;
            res.frame_done   = 1'b1;
            res.bad_encoding = 1'b1;
        end
        else if (emit)
        begin
            res_valid      = 1'b1;
            res.data_valid = 1'b1;
            res.out_byte   = e_byte;
            res.run_count  = e_cnt;
            if (beat.last_in)
            begin
                res.frame_done = 1'b1;
                phase_next     = PHASE_CONTROL;
                run_left_next  = 8'd0;
                bytes_next     = '0;
            end
        end
    end

    // State registers; a mode write restarts the frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_mode_reg <= 1'b0;
            phase_reg    <= PHASE_CONTROL;
            run_left_reg <= 8'd0;
            bytes_reg    <= '0;
            discard_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            raw_mode_reg <= cfg_wdata;
            phase_reg    <= PHASE_CONTROL;
            run_left_reg <= 8'd0;
            bytes_reg    <= '0;
            discard_reg  <= 1'b0;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            run_left_reg <= run_left_next;
            bytes_reg    <= bytes_next;
            discard_reg  <= discard_next;
        end
    end

    // Checks
    a_bad_is_end: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.bad_encoding |-> res.frame_done && !res.data_valid)
        else $error("error result without frame end or with data");

    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.data_valid |-> res.run_count != 8'd0)
        else $error("data result with zero run count");

    a_discard_clean: assert property (@(posedge clk) disable iff (!rst_n)
        discard_reg |-> phase_reg == PHASE_CONTROL && bytes_reg == '0)
        else $error("discarding with live frame state");

    a_raw_phase: assert property (@(posedge clk) disable iff (!rst_n)
        raw_mode_reg |-> phase_reg == PHASE_CONTROL && run_left_reg == 8'd0)
        else $error("run-length phase active in raw mode");

    a_bytes_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(bytes_reg) <= CMP_W'(FRAME_BYTES))
        else $error("byte count past frame size");

endmodule

// ===== rtl/run_length_frame_decoder_top.sv =====
// A beat in the input register decodes to zero or one result; a result is
// loaded into the result register and drives dec_valid (two register stages).
// Throughput: one encoded beat per cycle unless dec_stall backs up.
// The result register lets a new beat enter while a result waits downstream.
// Reset (rst_n, async low) empties both stages, selects run-length mode and
// starts a fresh frame; a raw_mode write also starts a fresh frame.
`timescale 1ns / 1ps

module run_length_frame_decoder_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_wdata,
    input  logic                enc_valid,
    output logic                enc_stall,
    input  rlfd_pkg::enc_beat_t enc_data,
    output logic                dec_valid,
    input  logic                dec_stall,
    output rlfd_pkg::dec_beat_t dec_data
);
    import rlfd_pkg::*;

    logic      in_valid_reg, in_valid_next;
    enc_beat_t in_beat_reg;
    logic      out_valid_reg, out_valid_next;
    dec_beat_t out_beat_reg;

    logic      res_valid;
    dec_beat_t res;
    logic      out_free;
    logic      advance;
    logic      take;

    // Input stage moves on when its result (if any) has room
    assign out_free  = !out_valid_reg || !dec_stall;
    assign advance   = in_valid_reg && (!res_valid || out_free);
    assign enc_stall = in_valid_reg && !advance;
    assign take      = enc_valid && !enc_stall;

    assign in_valid_next  = take ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = (advance && res_valid) ? 1'b1
                          : (dec_stall ? out_valid_reg : 1'b0);

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_beat_reg <= enc_data;
        end
    end

    // Decode logic and frame state
    rlfd_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .step      (advance),
        .beat      (in_beat_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
        begin
            out_beat_reg <= res;
        end
    end

    assign dec_valid = out_valid_reg;
    assign dec_data  = out_beat_reg;

    // Checks
    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        advance && res_valid |-> out_free)
        else $error("result loaded over an untaken beat");

    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_beat_reg))
        else $error("stalled input beat lost");

    a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
        advance && res_valid |=> dec_valid)
        else $error("result not presented");

endmodule

// ===== tb/tb_top.sv =====
// tb_top: self-checking bench for run_length_frame_decoder_top. A built-in decoder
// model predicts every result beat. Frames are directed, random and broken, in both modes.
// Depends on rlfd_pkg and the RTL of run_length_frame_decoder_top only.
`timescale 1ns / 1ps

module tb_top;
    import rlfd_pkg::*;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      cfg_we    = 1'b0;
    logic      cfg_wdata = 1'b0;
    logic      enc_valid = 1'b0;
    enc_beat_t enc_data  = '0;
    logic      dec_stall = 1'b0;
    logic      enc_stall;
    logic      dec_valid;
    dec_beat_t dec_data;

    // encoded beats waiting to be driven, decoded beats still owed by the block
    enc_beat_t enc_q[$];
    dec_beat_t want_q[$];

    int   idle_max   = 6;
    int   gap_left   = 0;
    int   stall_left = 0;
    int   err_count  = 0;
    int   items_sent = 0;
    logic enc_took   = 1'b0;
    logic dec_took   = 1'b0;

    // decoder model state
    logic             pred_raw   = 1'b0;
    logic [1:0]       pred_phase = PHASE_CONTROL;
    logic [7:0]       pred_left  = '0;
    logic [CNT_W-1:0] pred_count = '0;
    logic             pred_drop  = 1'b0;

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    run_length_frame_decoder_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .enc_valid (enc_valid),
        .enc_stall (enc_stall),
        .enc_data  (enc_data),
        .dec_valid (dec_valid),
        .dec_stall (dec_stall),
        .dec_data  (dec_data)
    );

    task automatic flag_error(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        err_count++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            flag_error($sformatf("%s got %0h, want %0h", name, got, want));
    endtask

    // ---------------- decoder model ----------------

    task automatic frame_reset();
        pred_phase = PHASE_CONTROL;
        pred_left  = '0;
        pred_count = '0;
        pred_drop  = 1'b0;
    endtask

    task automatic set_mode(input logic v);
        pred_raw = v;
        frame_reset();
    endtask

    // error beat ends the frame; without last the rest of the frame is dropped
    task automatic frame_error(input logic last);
        dec_beat_t r;
        frame_reset();
        if (!last)
            pred_drop = 1'b1;
        r = '0;
        r.frame_done   = 1'b1;
        r.bad_encoding = 1'b1;
        want_q.push_back(r);
    endtask

    task automatic emit_out(input logic [7:0] val, input logic [7:0] cnt, input logic last);
        dec_beat_t r;
        if (last && pred_count != FRAME_BYTES)
        begin
            frame_error(1'b1);  // short frame
        end
        else
        begin
            r = '0;
            r.data_valid = 1'b1;
            r.out_byte   = val;
            r.run_count  = cnt;
            r.frame_done = last;
            if (last)
                frame_reset();
            want_q.push_back(r);
        end
    endtask

    task automatic decode_beat(input enc_beat_t b);
        int         space;
        int         n;
        logic [7:0] rep;
        space = FRAME_BYTES - int'(pred_count);
        n     = int'(b.in_byte & CTRL_COUNT_MASK) + 1;
        if (pred_drop)
        begin
            if (b.last_in)
                frame_reset();
        end
        else if (pred_raw)
        begin
            if (space <= 0)
                frame_error(b.last_in);
            else
            begin
                pred_count++;
                emit_out(b.in_byte, 8'd1, b.last_in);
            end
        end
        else
        begin
            case (pred_phase)
                PHASE_LITERAL:
                begin
                    if (pred_left == 0 || space <= 0)
                        frame_error(b.last_in);
                    else
                    begin
                        pred_left--;
                        pred_count++;
                        if (pred_left == 0)
                        begin
                            pred_phase = PHASE_CONTROL;
                            emit_out(b.in_byte, 8'd1, b.last_in);
                        end
                        else if (b.last_in)
                            frame_error(1'b1);  // truncated literal group
                        else
                            emit_out(b.in_byte, 8'd1, 1'b0);
                    end
                end
                PHASE_REPEAT:
                begin
                    if (pred_left == 0 || int'(pred_left) > space)
                        frame_error(b.last_in);
                    else
                    begin
                        rep        = pred_left;
                        pred_count = pred_count + rep;
                        pred_left  = '0;
                        pred_phase = PHASE_CONTROL;
                        emit_out(b.in_byte, rep, b.last_in);
                    end
                end
                default:
                begin
                    if (space <= 0 || n > space)
                        frame_error(b.last_in);  // overflow
                    else if (b.last_in)
                        frame_error(1'b1);       // truncated on control byte
                    else
                    begin
                        pred_left  = n[7:0];
                        pred_phase = ((b.in_byte & CTRL_REPEAT_BIT) != 0) ?
                                     PHASE_REPEAT : PHASE_LITERAL;
                    end
                end
            endcase
        end
    endtask

    // ---------------- beat capture: check results, then predict ----------------

    always @(posedge clk)
    begin
        dec_beat_t w;
        enc_took <= rst_n && enc_valid && !enc_stall;
        dec_took <= rst_n && dec_valid && !dec_stall;
        if (rst_n && dec_valid && !dec_stall)
        begin
            if (want_q.size() == 0)
                flag_error($sformatf("unexpected result beat %h", dec_data));
            else
            begin
                w = want_q.pop_front();
                check_field("data_valid", int'(dec_data.data_valid),
                            int'(w.data_valid));
                check_field("out_byte", int'(dec_data.out_byte), int'(w.out_byte));
                check_field("run_count", int'(dec_data.run_count), int'(w.run_count));
                check_field("frame_done", int'(dec_data.frame_done),
                            int'(w.frame_done));
                check_field("bad_encoding", int'(dec_data.bad_encoding),
                            int'(w.bad_encoding));
            end
        end
        if (rst_n && enc_valid && !enc_stall)
            decode_beat(enc_data);
    end

    // ---------------- driver ----------------

    always @(negedge clk)
    begin
        if (!rst_n)
            enc_valid <= 1'b0;
        else if (enc_valid && !enc_took)
        begin
            // beat still waiting: hold it
        end
        else if (gap_left > 0)
        begin
            enc_valid <= 1'b0;
            gap_left--;
        end
        else if (enc_q.size() > 0)
        begin
            enc_data  <= enc_q.pop_front();
            enc_valid <= 1'b1;
            gap_left  = $urandom_range(0, idle_max);
        end
        else
            enc_valid <= 1'b0;
    end

    // ---------------- result-side stall ----------------

    always @(negedge clk)
    begin
        if (dec_took)
            stall_left = $urandom_range(0, idle_max);
        if (stall_left > 0)
        begin
            dec_stall <= 1'b1;
            stall_left--;
        end
        else
            dec_stall <= 1'b0;
    end

    // ---------------- stimulus helpers ----------------

    task automatic push_byte(input logic [7:0] v, input logic last);
        enc_beat_t b;
        b.in_byte = v;
        b.last_in = last;
        enc_q.push_back(b);
        items_sent++;
    endtask

    // runs and literal groups that decode to exactly target bytes
    task automatic push_runs(input int target, input logic fin);
        int remain;
        int m;
        int k;
        int cap;
        remain = target;
        while (remain > 0)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                cap = (remain < 4) ? remain : 4;
                m   = $urandom_range(1, cap);
                push_byte(8'(m - 1), 1'b0);
                for (k = 0; k < m; k++)
                    push_byte(8'($urandom), fin && remain == m && k == m - 1);
            end
            else
            begin
                cap = (remain < 128) ? remain : 128;
                if ($urandom_range(0, 1) == 1)
                    m = cap;
                else
                    m = $urandom_range(1, cap);
                push_byte(CTRL_REPEAT_BIT | 8'(m - 1), 1'b0);
                push_byte(8'($urandom), fin && remain == m);
            end
            remain -= m;
        end
    endtask

    // bytes dropped after an error, closed by last
    task automatic push_tail();
        repeat ($urandom_range(0, 5))
            push_byte(8'($urandom), 1'b0);
        push_byte(8'($urandom), 1'b1);
    endtask

    task automatic push_raw(input int count, input logic fin);
        int i;
        for (i = 0; i < count; i++)
            push_byte(8'($urandom), fin && i == count - 1);
    endtask

    task automatic gen_rle_frame();
        int kind;
        int pre;
        int cap;
        int m;
        int k;
        int i;
        kind = $urandom_range(0, 10);
        case (kind)
            5:  push_runs($urandom_range(1, FRAME_BYTES - 1), 1'b1);  // short frame
            6:
            begin
                // last on a control byte
                push_runs($urandom_range(0, FRAME_BYTES - 1), 1'b0);
                push_byte(8'($urandom), 1'b1);
            end
            7:
            begin
                // last in the middle of a literal group
                pre = $urandom_range(0, FRAME_BYTES - 2);
                cap = FRAME_BYTES - pre;
                if (cap > 128)
                    cap = 128;
                m = $urandom_range(2, cap);
                push_runs(pre, 1'b0);
                push_byte(8'(m - 1), 1'b0);
                k = $urandom_range(1, m - 1);
                for (i = 0; i < k; i++)
                    push_byte(8'($urandom), i == k - 1);
            end
            8:
            begin
                // count larger than the space left
                pre = $urandom_range(FRAME_BYTES - 127, FRAME_BYTES - 1);
                m   = $urandom_range(FRAME_BYTES - pre + 1, 128);
                push_runs(pre, 1'b0);
                push_byte((($urandom_range(0, 1) == 1) ? CTRL_REPEAT_BIT : 8'h00) |
                          8'(m - 1), 1'b0);
                push_tail();
            end
            9:
            begin
                // control byte after the frame is already full
                push_runs(FRAME_BYTES, 1'b0);
                if ($urandom_range(0, 3) == 0)
                    push_byte(8'($urandom), 1'b1);
                else
                begin
                    push_byte(8'($urandom), 1'b0);
                    push_tail();
                end
            end
            10:
            begin
                // noise, closed by last so the next frame starts clean
                repeat ($urandom_range(1, 6))
                    push_byte(8'($urandom), 1'b0);
                push_byte(8'($urandom), 1'b1);
            end
            default: push_runs(FRAME_BYTES, 1'b1);
        endcase
    endtask

    task automatic wait_idle();
        @(negedge clk);
        while (enc_q.size() != 0 || enc_valid || want_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_mode(input logic v);
        wait_idle();
        cfg_wdata <= v;
        cfg_we    <= 1'b1;
        @(posedge clk);
        set_mode(v);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic rle_phase(input int count);
        int stop;
        stop = items_sent + count;
        while (items_sent < stop)
            gen_rle_frame();
    endtask

    // ---------------- test sequence ----------------

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_mode(1'b0);

        // directed: extreme counts, literal and repeat, truncation, short frame
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'hA5, 1'b1);
        push_byte(8'h05, 1'b1);
        push_byte(8'h02, 1'b0);
        push_byte(8'h11, 1'b0);
        push_byte(8'h22, 1'b1);
        // mode change abandons a pending repeat
        push_byte(8'h83, 1'b0);
        write_mode(1'b1);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b1);
        push_byte(8'h7F, 1'b0);
        write_mode(1'b0);

        // random run-length frames with idling on both sides
        idle_max = 6;
        rle_phase(180);

        // raw mode: short frames back to back, then with idling
        write_mode(1'b1);
        idle_max = 0;
        repeat (3)
            push_raw($urandom_range(1, 20), 1'b1);
        wait_idle();
        idle_max = 6;
        repeat (3)
            push_raw($urandom_range(1, 20), 1'b1);
        push_raw(7, 1'b0);
        write_mode(1'b0);

        // run-length again: back-to-back, then idling with a mid-frame write
        idle_max = 0;
        rle_phase(80);
        wait_idle();
        idle_max = 6;
        rle_phase(80);
        push_runs(300, 1'b0);
        write_mode(1'b0);
        rle_phase(40);

        wait_idle();
        repeat (6) @(negedge clk);
        if (err_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // watchdog
    initial
    begin
        #3000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
